FILE: sv/flv_container_parser_assert.svh
// assertion macros for the flv container parser
`ifndef FLV_CONTAINER_PARSER_ASSERT_SVH
`define FLV_CONTAINER_PARSER_ASSERT_SVH

// checked property, disabled while reset is high
`define FLVCP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked property that also holds through reset
`define FLVCP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/flvcp_pkg.sv
package flvcp_pkg;

  // parser phase
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_TAGHDR,
    PH_PAYLOAD,
    PH_BACKPTR
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_TAG    = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_SIG   = 2'd1;
  localparam logic [1:0] ST_BAD_VALUE = 2'd2;
  localparam logic [1:0] ST_CORRUPT   = 2'd3;

  // signature and header constants
  localparam logic [7:0] CHAR_F          = 8'h46;
  localparam logic [7:0] CHAR_L          = 8'h4C;
  localparam logic [7:0] CHAR_V          = 8'h56;
  localparam logic [7:0] HDR_DATA_OFFSET = 8'd9;

  // byte positions
  localparam logic [23:0] HDR_LAST_IDX    = 24'd12;
  localparam logic [23:0] TAGHDR_LAST_IDX = 24'd10;
  localparam logic [23:0] BACK_PTR_LAST   = 24'd3;
  localparam logic [31:0] TAG_HEADER_LEN  = 32'd11;

  // tag types and codec
  localparam logic [7:0] TYPE_AUDIO  = 8'd8;
  localparam logic [7:0] TYPE_VIDEO  = 8'd9;
  localparam logic [7:0] TYPE_SCRIPT = 8'd18;
  localparam logic [3:0] CODEC_AVC   = 4'd7;
  localparam logic [7:0] AVC_NALU    = 8'd1;

endpackage

FILE: sv/flv_container_parser.sv
// a byte is held in the input register, parsed combinationally, and its result is
//   stored in the result register; an output stall holds both registers
// throughput: one byte per cycle unless stalled; single-pass parse sets no other limit
// reset: synchronous rst clears the phase, counters, flags and captured fields;
//   after an error or a completed final item, bytes are taken and dropped
//   until the next reset
module flv_container_parser
  import flvcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [1:0]  status,
  output logic [7:0]  version,
  output logic [1:0]  av_flags,
  output logic [7:0]  tag_type,
  output logic [23:0] data_size,
  output logic [23:0] timestamp,
  output logic [7:0]  timestamp_ext,
  output logic [23:0] stream_id,
  output logic [7:0]  first_payload_byte,
  output logic [7:0]  avc_packet_type,
  output logic [23:0] composition_time
);

  `include "flv_container_parser_assert.svh"

  // input register
  logic       in_q_valid;
  logic [7:0] in_byte;
  logic       in_eos;

  // parser state
  phase_t      phase, phase_next;
  logic [23:0] byte_count, byte_count_next;
  logic        stopped, stopped_next;
  logic        bad_sig, bad_sig_next;
  logic        bad_value, bad_value_next;
  logic [7:0]  file_version, file_version_next;
  logic [1:0]  media_flags, media_flags_next;
  logic [7:0]  cur_type, cur_type_next;
  logic [23:0] cur_size, cur_size_next;
  logic [23:0] cur_ts, cur_ts_next;
  logic [7:0]  cur_ts_ext, cur_ts_ext_next;
  logic [23:0] cur_sid, cur_sid_next;
  logic [7:0]  cur_first, cur_first_next;
  logic [7:0]  cur_avc, cur_avc_next;
  logic [23:0] cur_ctime, cur_ctime_next;
  logic [31:0] back_pointer, back_pointer_next;

  // result of the current byte
  logic        res_valid;
  logic [1:0]  res_kind;
  logic [1:0]  res_status;
  logic [7:0]  res_version;
  logic [1:0]  res_flags;
  logic [7:0]  res_type;
  logic [23:0] res_size;
  logic [23:0] res_ts;
  logic [7:0]  res_ts_ext;
  logic [23:0] res_sid;
  logic [7:0]  res_first;
  logic [7:0]  res_avc;
  logic [23:0] res_ctime;

  logic out_blocked;
  logic adv;
  logic accept;

  // handshake: the input register moves on whenever the result register can take a result
  assign out_blocked = out_valid && out_stall;
  assign adv         = in_q_valid && !out_blocked;
  assign in_stall    = in_q_valid && out_blocked;
  assign accept      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (accept) begin
      in_q_valid <= 1'b1;
    end else if (adv) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= data_byte;
      in_eos  <= end_of_stream;
    end
  end

  // per-byte parse
  always_comb begin
    logic        boundary;
    logic        failed;
    logic [23:0] bc_inc;
    logic        avc;
    phase_next        = phase;
    byte_count_next   = byte_count;
    stopped_next      = stopped;
    bad_sig_next      = bad_sig;
    bad_value_next    = bad_value;
    file_version_next = file_version;
    media_flags_next  = media_flags;
    cur_type_next     = cur_type;
    cur_size_next     = cur_size;
    cur_ts_next       = cur_ts;
    cur_ts_ext_next   = cur_ts_ext;
    cur_sid_next      = cur_sid;
    cur_first_next    = cur_first;
    cur_avc_next      = cur_avc;
    cur_ctime_next    = cur_ctime;
    back_pointer_next = back_pointer;
    res_valid   = 1'b0;
    res_kind    = KIND_HEADER;
    res_status  = ST_OK;
    res_version = '0;
    res_flags   = '0;
    res_type    = '0;
    res_size    = '0;
    res_ts      = '0;
    res_ts_ext  = '0;
    res_sid     = '0;
    res_first   = '0;
    res_avc     = '0;
    res_ctime   = '0;
    boundary    = 1'b0;
    failed      = 1'b0;
    bc_inc      = byte_count + 24'd1;
    avc         = 1'b0;

    if (adv && !stopped) begin
      case (phase)
        PH_HEADER: begin
          if (byte_count == 24'd0 && in_byte != CHAR_F) bad_sig_next = 1'b1;
          if (byte_count == 24'd1 && in_byte != CHAR_L) bad_sig_next = 1'b1;
          if (byte_count == 24'd2 && in_byte != CHAR_V) bad_sig_next = 1'b1;
          if (byte_count == 24'd3) file_version_next = in_byte;
          if (byte_count == 24'd4) media_flags_next = {in_byte[2], in_byte[0]};
          if (byte_count >= 24'd5 && byte_count <= 24'd7 && in_byte != 8'd0) begin
            bad_value_next = 1'b1;
          end
          if (byte_count == 24'd8 && in_byte != HDR_DATA_OFFSET) bad_value_next = 1'b1;
          byte_count_next = bc_inc;
          if (byte_count == HDR_LAST_IDX) begin
            res_valid       = 1'b1;
            boundary        = 1'b1;
            phase_next      = PH_TAGHDR;
            byte_count_next = '0;
            if (bad_sig_next) begin
              res_kind   = KIND_ERROR;
              res_status = ST_BAD_SIG;
              failed     = 1'b1;
            end else if (bad_value_next) begin
              res_kind   = KIND_ERROR;
              res_status = ST_BAD_VALUE;
              failed     = 1'b1;
            end else begin
              res_kind    = KIND_HEADER;
              res_version = file_version;
              res_flags   = media_flags;
            end
          end
        end
        PH_TAGHDR: begin
          if (byte_count == 24'd0) begin
            cur_type_next     = in_byte;
            cur_size_next     = '0;
            cur_ts_next       = '0;
            cur_ts_ext_next   = '0;
            cur_sid_next      = '0;
            cur_first_next    = '0;
            cur_avc_next      = '0;
            cur_ctime_next    = '0;
            back_pointer_next = '0;
          end else if (byte_count <= 24'd3) begin
            cur_size_next = {cur_size[15:0], in_byte};
          end else if (byte_count <= 24'd6) begin
            cur_ts_next = {cur_ts[15:0], in_byte};
          end else if (byte_count == 24'd7) begin
            cur_ts_ext_next = in_byte;
          end else begin
            cur_sid_next = {cur_sid[15:0], in_byte};
          end
          byte_count_next = bc_inc;
          if (byte_count == TAGHDR_LAST_IDX) begin
            byte_count_next = '0;
            phase_next      = (cur_size != 24'd0) ? PH_PAYLOAD : PH_BACKPTR;
          end
        end
        PH_PAYLOAD: begin
          if (byte_count == 24'd0) cur_first_next = in_byte;
          else if (byte_count == 24'd1) cur_avc_next = in_byte;
          else if (byte_count == 24'd2) cur_ctime_next = {in_byte, cur_ctime[15:0]};
          else if (byte_count == 24'd3)
            cur_ctime_next = {cur_ctime[23:16], in_byte, cur_ctime[7:0]};
          else if (byte_count == 24'd4) cur_ctime_next = {cur_ctime[23:8], in_byte};
          byte_count_next = bc_inc;
          if (bc_inc >= cur_size) begin
            byte_count_next = '0;
            phase_next      = PH_BACKPTR;
          end
        end
        default: begin
          back_pointer_next = {back_pointer[23:0], in_byte};
          byte_count_next   = bc_inc;
          if (byte_count == BACK_PTR_LAST) begin
            res_valid       = 1'b1;
            boundary        = 1'b1;
            phase_next      = PH_TAGHDR;
            byte_count_next = '0;
            if (back_pointer_next != {8'd0, cur_size} + TAG_HEADER_LEN) begin
              res_kind   = KIND_ERROR;
              res_status = ST_CORRUPT;
              failed     = 1'b1;
            end else if (cur_type != TYPE_AUDIO && cur_type != TYPE_VIDEO &&
                         cur_type != TYPE_SCRIPT) begin
              res_kind   = KIND_ERROR;
              res_status = ST_BAD_VALUE;
              failed     = 1'b1;
            end else begin
              avc        = (cur_type == TYPE_VIDEO) && (cur_first[3:0] == CODEC_AVC);
              res_kind   = KIND_TAG;
              res_type   = cur_type;
              res_size   = cur_size;
              res_ts     = cur_ts;
              res_ts_ext = cur_ts_ext;
              res_sid    = cur_sid;
              res_first  = cur_first;
              res_avc    = avc ? cur_avc : 8'd0;
              res_ctime  = (avc && cur_avc == AVC_NALU) ? cur_ctime : 24'd0;
            end
          end
        end
      endcase

      // stop on error, or on the last byte of the file
      if (failed) begin
        stopped_next = 1'b1;
      end else if (in_eos) begin
        if (!boundary) begin
          res_valid   = 1'b1;
          res_kind    = KIND_ERROR;
          res_status  = ST_CORRUPT;
          res_version = '0;
          res_flags   = '0;
        end
        stopped_next = 1'b1;
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      byte_count   <= '0;
      stopped      <= 1'b0;
      bad_sig      <= 1'b0;
      bad_value    <= 1'b0;
      file_version <= '0;
      media_flags  <= '0;
      cur_type     <= '0;
      cur_size     <= '0;
      cur_ts       <= '0;
      cur_ts_ext   <= '0;
      cur_sid      <= '0;
      cur_first    <= '0;
      cur_avc      <= '0;
      cur_ctime    <= '0;
      back_pointer <= '0;
    end else begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      stopped      <= stopped_next;
      bad_sig      <= bad_sig_next;
      bad_value    <= bad_value_next;
      file_version <= file_version_next;
      media_flags  <= media_flags_next;
      cur_type     <= cur_type_next;
      cur_size     <= cur_size_next;
      cur_ts       <= cur_ts_next;
      cur_ts_ext   <= cur_ts_ext_next;
      cur_sid      <= cur_sid_next;
      cur_first    <= cur_first_next;
      cur_avc      <= cur_avc_next;
      cur_ctime    <= cur_ctime_next;
      back_pointer <= back_pointer_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (res_valid) begin
      kind               <= res_kind;
      status             <= res_status;
      version            <= res_version;
      av_flags           <= res_flags;
      tag_type           <= res_type;
      data_size          <= res_size;
      timestamp          <= res_ts;
      timestamp_ext      <= res_ts_ext;
      stream_id          <= res_sid;
      first_payload_byte <= res_first;
      avc_packet_type    <= res_avc;
      composition_time   <= res_ctime;
    end
  end

  // checks
  `FLVCP_ASSERT(a_stopped_sticky, stopped |=> stopped,
    "parser left the stopped state without reset")
  `FLVCP_ASSERT_ALWAYS(a_no_result_when_stopped, res_valid |-> (adv && !stopped),
    "result produced while stopped or idle")
  `FLVCP_ASSERT(a_error_has_status,
    (out_valid && kind == KIND_ERROR) |-> (status != ST_OK), "error result with ok status")
  `FLVCP_ASSERT(a_item_done_to_taghdr,
    (res_valid && res_kind != KIND_ERROR) |=> (phase == PH_TAGHDR),
    "completed item did not return to tag header")
  `FLVCP_ASSERT(a_taghdr_count, (phase == PH_TAGHDR) |-> (byte_count <= TAGHDR_LAST_IDX),
    "tag header byte count out of range")

endmodule
